// ===== rtl/mf_pkg.sv =====
// Shared types, constants and register codes of the 3x3 median filter.
package mf_pkg;

    // Field and register widths
    localparam int PIX_W  = 8;
    localparam int DIM_W  = 12;
    localparam int CELLS  = 9;

    // Size limits and register reset values
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;
    localparam int DIM_RESET      = 2048;

    // Sorting network stages of the median unit
    localparam int MED_LAT = 3;

    // Result queue depth, a power of two
    localparam int OUTQ_DEPTH = 16;

    // Configuration port
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_SEL_BIT = 2;

    // Register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Item kinds
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    // 3x3 window, cell index is row * 3 + column
    typedef t_pix [CELLS-1:0] t_cells;

    typedef struct packed {
        logic mode;
        t_pix pixel;
    } t_in;

    typedef struct packed {
        t_pix median;
        logic end_of_row;
        logic end_of_image;
    } t_out;

    // Up to two results written into the result queue per cycle, first lane first
    typedef struct packed {
        logic en1;
        logic en2;
        t_out res1;
        t_out res2;
    } t_push;

endpackage

// ===== rtl/mf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
module mf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when both ports hit the same entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mf_median.sv =====
// Pipelined median-of-nine sorting network, three register stages.
module mf_median (
    input  logic           i_clk,
    input  mf_pkg::t_cells i_cells,
    output mf_pkg::t_pix   o_median
);

    function automatic logic [3*mf_pkg::PIX_W-1:0] sort3(
        mf_pkg::t_pix a, mf_pkg::t_pix b, mf_pkg::t_pix c);
        mf_pkg::t_pix x;
        mf_pkg::t_pix y;
        mf_pkg::t_pix z;
        mf_pkg::t_pix t;
        begin
            x = a;
            y = b;
            z = c;
            if (x > y) begin
                t = x; x = y; y = t;
            end
            if (y > z) begin
                t = y; y = z; z = t;
            end
            if (x > y) begin
                t = x; x = y; y = t;
            end
            return {z, y, x};
        end
    endfunction

    function automatic mf_pkg::t_pix min2(mf_pkg::t_pix a, mf_pkg::t_pix b);
        return (a < b) ? a : b;
    endfunction

    function automatic mf_pkg::t_pix max2(mf_pkg::t_pix a, mf_pkg::t_pix b);
        return (a > b) ? a : b;
    endfunction

    function automatic mf_pkg::t_pix med3(
        mf_pkg::t_pix a, mf_pkg::t_pix b, mf_pkg::t_pix c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    mf_pkg::t_pix r_lo [3];
    mf_pkg::t_pix r_mi [3];
    mf_pkg::t_pix r_hi [3];
    mf_pkg::t_pix r_max_lo;
    mf_pkg::t_pix r_med_mi;
    mf_pkg::t_pix r_min_hi;
    mf_pkg::t_pix r_med;

    // Stage 1: sort each window row
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            {r_hi[i], r_mi[i], r_lo[i]} <=
                sort3(i_cells[i*3], i_cells[i*3+1], i_cells[i*3+2]);
        end
    end

    // Stage 2: largest low, middle of middles, smallest high
    always_ff @(posedge i_clk) begin
        r_max_lo <= max2(max2(r_lo[0], r_lo[1]), r_lo[2]);
        r_med_mi <= med3(r_mi[0], r_mi[1], r_mi[2]);
        r_min_hi <= min2(min2(r_hi[0], r_hi[1]), r_hi[2]);
    end

    // Stage 3: median of the three survivors
    always_ff @(posedge i_clk) begin
        r_med <= med3(r_max_lo, r_med_mi, r_min_hi);
    end

    assign o_median = r_med;

endmodule

// ===== rtl/mf_outq.sv =====
// Result queue: up to two writes and one read per cycle.
module mf_outq #(
    parameter int DEPTH = mf_pkg::OUTQ_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mf_pkg::t_push              i_push,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output logic                       o_valid,
    output mf_pkg::t_out               o_data,
    input  logic                       i_stall
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mf_pkg::t_out r_mem [DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wp2;
    logic          pop;

    assign n_wp2 = r_wp + PW'(i_push.en1);
    assign pop   = o_valid && !i_stall;

    // Entry storage, second lane lands behind the first
    always_ff @(posedge i_clk) begin
        if (i_push.en1) begin
            r_mem[r_wp] <= i_push.res1;
        end
        if (i_push.en2) begin
            r_mem[n_wp2] <= i_push.res2;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp2 + PW'(i_push.en2);
            r_rp    <= r_rp + PW'(pop);
            r_count <= r_count + CW'(i_push.en1) + CW'(i_push.en2) - CW'(pop);
        end
    end

    assign o_count = r_count;
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rp];

endmodule

// ===== rtl/median_filter_3x3.sv =====
// Top level of the 3x3 median filter: line stores, window, control and config port.
//
// Input channel (i_in_valid / o_in_stall / i_in_data): one item per transfer,
// mode 0 carries the next pixel of the image in raster order, mode 1 is a flush
// item; after the last pixel, one flush item per column gives the bottom row.
// Output channel (o_out_valid / i_out_stall / o_out_data): medians in raster
// order with end-of-row and end-of-image flags.
// Registers image_width (byte address 0) and image_height (byte address 4) are
// written over the APB port while the block is idle, a rule for the user that the
// block does not enforce; values are clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT.
// Throughput: one item per clock while o_in_stall is low. The line stores are
// one RAM pair read at the accept edge and written back in the following cycle,
// with forwarding on a repeated column. An item's results pass the read/write-back
// and median input registers and the sorting network into a 16-entry result queue;
// the last pixel of a row from the second row on gives two results. Results leave
// at one per cycle; when the receiver stalls, they collect in the queue and
// o_in_stall rises once the queue and the items in flight could fill it.
// Reset clears the indices, the pipeline and the queue and sets both registers
// to 2048; line store contents are not cleared and need no clearing pass.
module median_filter_3x3 #(
    parameter int MAX_WIDTH  = mf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = mf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input item channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  mf_pkg::t_in                 i_in_data,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output mf_pkg::t_out                o_out_data,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mf_pkg::APB_AW-1:0]   paddr,
    input  logic [mf_pkg::APB_DW-1:0]   pwdata,
    output logic [mf_pkg::APB_DW-1:0]   prdata,
    output logic                        pready
);

    localparam int AW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT + 1);
    localparam int CMP_W  = mf_pkg::DIM_W + 2;
    localparam int LAT    = mf_pkg::MED_LAT;
    localparam int QCW    = $clog2(mf_pkg::OUTQ_DEPTH + 1);
    localparam int INFL_W = $clog2(LAT + 3);
    localparam int LOAD_W = $clog2(mf_pkg::OUTQ_DEPTH + 2 * (LAT + 2) + 3);

    // Decisions taken at the transfer, used in the following cycle
    typedef struct packed {
        logic          flush;
        logic [AW-1:0] addr;
        mf_pkg::t_pix  px;
        logic          clr;
        logic          top_en;
        logic          mid_en;
        logic          k0;
        logic [2:0]    mask;
        logic          emit1;
        logic          emit2;
        logic          last;
        logic          fwd;
    } t_stb;

    typedef struct packed {
        logic emit1;
        logic emit2;
        logic last;
    } t_flg;

    function automatic logic [mf_pkg::DIM_W-1:0] clamp_dim(
        logic [mf_pkg::DIM_W-1:0] v, int maxv);
        if (v == '0) begin
            return mf_pkg::DIM_W'(1);
        end
        if (int'(v) > maxv) begin
            return mf_pkg::DIM_W'(maxv);
        end
        return v;
    endfunction

    // Config registers
    logic [mf_pkg::DIM_W-1:0] r_width;
    logic [mf_pkg::DIM_W-1:0] r_height;
    logic                     cfg_wr;

    // Position state
    logic [RW-1:0] r_row;
    logic [AW-1:0] r_col;
    logic [AW-1:0] r_fidx;
    logic [RW-1:0] n_row;
    logic [AW-1:0] n_col;
    logic [AW-1:0] n_fidx;

    // Transfer-side decode
    logic          in_acc;
    logic          is_flush;
    logic          row_lt_h;
    logic          px_act;
    logic          fl_act;
    logic          col_last;
    logic          fl_last;
    logic          row_ge1;
    logic          row_ge2;
    logic [AW-1:0] rd_addr;
    t_stb          n_b;

    // Read/write-back stage
    logic          r_b_vld;
    t_stb          r_b;
    mf_pkg::t_pix  r_fwd_up;
    mf_pkg::t_pix  r_fwd_mid;
    mf_pkg::t_pix  ram_up_q;
    mf_pkg::t_pix  ram_mid_q;
    mf_pkg::t_pix  up_q;
    mf_pkg::t_pix  mid_q;
    mf_pkg::t_pix  top_v;
    mf_pkg::t_pix  mid_v;
    logic          wr_en;

    // Windows
    mf_pkg::t_cells             r_win;
    mf_pkg::t_cells             n_win;
    logic [2:0][mf_pkg::PIX_W-1:0] r_fl_top;
    logic [2:0][mf_pkg::PIX_W-1:0] r_fl_mid;
    logic [2:0][mf_pkg::PIX_W-1:0] n_fl_top;
    logic [2:0][mf_pkg::PIX_W-1:0] n_fl_mid;
    mf_pkg::t_pix               r_c0_top;
    mf_pkg::t_pix               r_c0_mid;
    mf_pkg::t_cells             n_cells1;
    mf_pkg::t_cells             n_cells2;

    // Median inputs and flag pipe
    logic           r_c_vld;
    mf_pkg::t_cells r_c_cells1;
    mf_pkg::t_cells r_c_cells2;
    t_flg           r_c_flg;
    logic [LAT-1:0] r_p_vld;
    t_flg           r_p_flg [LAT];
    mf_pkg::t_pix   med_a;
    mf_pkg::t_pix   med_b;

    // Result queue
    mf_pkg::t_push   push;
    logic [QCW-1:0]  q_count;
    logic [INFL_W-1:0] inflight;
    logic [LOAD_W-1:0] load;

    // ---------------------------------------------------------------
    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= clamp_dim(mf_pkg::DIM_W'(mf_pkg::DIM_RESET), MAX_WIDTH);
            r_height <= clamp_dim(mf_pkg::DIM_W'(mf_pkg::DIM_RESET), MAX_HEIGHT);
        end else if (cfg_wr) begin
            case (paddr[mf_pkg::REG_SEL_BIT])
                mf_pkg::REG_WIDTH: begin
                    r_width <= clamp_dim(pwdata[mf_pkg::DIM_W-1:0], MAX_WIDTH);
                end
                mf_pkg::REG_HEIGHT: begin
                    r_height <= clamp_dim(pwdata[mf_pkg::DIM_W-1:0], MAX_HEIGHT);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[mf_pkg::REG_SEL_BIT])
            mf_pkg::REG_WIDTH:  prdata = mf_pkg::APB_DW'(r_width);
            mf_pkg::REG_HEIGHT: prdata = mf_pkg::APB_DW'(r_height);
            default:            prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Transfer decode
    assign in_acc   = i_in_valid && !o_in_stall;
    assign is_flush = i_in_data.mode == mf_pkg::MODE_FLUSH;
    assign row_lt_h = CMP_W'(r_row) < CMP_W'(r_height);
    assign px_act   = !is_flush && row_lt_h;
    assign fl_act   = is_flush && !row_lt_h;
    assign col_last = CMP_W'(r_col) + CMP_W'(1) >= CMP_W'(r_width);
    assign fl_last  = CMP_W'(r_fidx) + CMP_W'(1) >= CMP_W'(r_width);
    assign row_ge1  = r_row != '0;
    assign row_ge2  = CMP_W'(r_row) >= CMP_W'(2);
    // a flush reads the column to the right of the one it reports
    assign rd_addr  = is_flush ? (r_fidx + AW'(1)) : r_col;

    always_comb begin
        n_b         = '0;
        n_b.flush   = is_flush;
        n_b.addr    = rd_addr;
        n_b.px      = i_in_data.pixel;
        n_b.clr     = r_col == '0;
        n_b.top_en  = row_ge2;
        n_b.mid_en  = is_flush || row_ge1;
        n_b.k0      = r_fidx == '0;
        n_b.mask[0] = (r_fidx != '0) && (CMP_W'(r_fidx) <= CMP_W'(r_width));
        n_b.mask[1] = CMP_W'(r_fidx) < CMP_W'(r_width);
        n_b.mask[2] = !fl_last;
        n_b.emit1   = is_flush || (row_ge1 && (r_col != '0));
        n_b.emit2   = !is_flush && row_ge1 && col_last;
        n_b.last    = is_flush && fl_last;
        // previous item writes this entry in the same cycle
        n_b.fwd     = r_b_vld && !r_b.flush && (r_b.addr == rd_addr);
    end

    // Position counters
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_fidx = r_fidx;
        if (in_acc && px_act) begin
            if (col_last) begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end else if (in_acc && fl_act) begin
            if (fl_last) begin
                n_row  = '0;
                n_col  = '0;
                n_fidx = '0;
            end else begin
                n_fidx = r_fidx + AW'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Line stores
    mf_ram #(
        .WIDTH (mf_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_b.addr),
        .i_wdata (mid_v),
        .i_raddr (rd_addr),
        .o_rdata (ram_up_q)
    );

    mf_ram #(
        .WIDTH (mf_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_b.addr),
        .i_wdata (r_b.px),
        .i_raddr (rd_addr),
        .o_rdata (ram_mid_q)
    );

    // Read data with forwarding, row masking, write-back
    assign up_q  = r_b.fwd ? r_fwd_up  : ram_up_q;
    assign mid_q = r_b.fwd ? r_fwd_mid : ram_mid_q;
    assign top_v = r_b.top_en ? up_q  : '0;
    assign mid_v = r_b.mid_en ? mid_q : '0;
    assign wr_en = r_b_vld && !r_b.flush;

    // Pixel window shift; a row start clears the older columns
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i*3]   = r_b.clr ? '0 : r_win[i*3+1];
            n_win[i*3+1] = r_b.clr ? '0 : r_win[i*3+2];
        end
        n_win[2] = top_v;
        n_win[5] = mid_v;
        n_win[8] = r_b.px;
    end

    // Flush window over raw line store columns k-1, k, k+1
    always_comb begin
        n_fl_top[2] = up_q;
        n_fl_mid[2] = mid_q;
        if (r_b.k0) begin
            n_fl_top[0] = '0;
            n_fl_mid[0] = '0;
            n_fl_top[1] = r_c0_top;
            n_fl_mid[1] = r_c0_mid;
        end else begin
            n_fl_top[0] = r_fl_top[1];
            n_fl_mid[0] = r_fl_mid[1];
            n_fl_top[1] = r_fl_top[2];
            n_fl_mid[1] = r_fl_mid[2];
        end
    end

    // Median unit inputs
    always_comb begin
        for (int d = 0; d < 3; d++) begin
            // right edge: window moved on by a zero column
            n_cells2[d*3]   = n_win[d*3+1];
            n_cells2[d*3+1] = n_win[d*3+2];
            n_cells2[d*3+2] = '0;
        end
        if (r_b.flush) begin
            for (int d = 0; d < 3; d++) begin
                n_cells1[d]   = (r_b.mask[d] && r_b.top_en) ? n_fl_top[d] : '0;
                n_cells1[3+d] = r_b.mask[d] ? n_fl_mid[d] : '0;
                n_cells1[6+d] = '0;
            end
        end else begin
            n_cells1 = n_win;
        end
    end

    // ---------------------------------------------------------------
    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_fidx  <= '0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_p_vld <= '0;
        end else begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_fidx  <= n_fidx;
            r_b_vld <= in_acc && (px_act || fl_act);
            r_c_vld <= r_b_vld;
            r_p_vld <= {r_p_vld[LAT-2:0], r_c_vld};
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_b        <= n_b;
        r_fwd_up   <= mid_v;
        r_fwd_mid  <= r_b.px;
        r_c_cells1 <= n_cells1;
        r_c_cells2 <= n_cells2;
        r_c_flg    <= '{emit1: r_b.emit1, emit2: r_b.emit2, last: r_b.last};
        r_p_flg[0] <= r_c_flg;
        for (int i = 1; i < LAT; i++) begin
            r_p_flg[i] <= r_p_flg[i-1];
        end
        if (wr_en) begin
            r_win <= n_win;
            if (r_b.clr) begin
                r_c0_top <= mid_v;
                r_c0_mid <= r_b.px;
            end
        end
        if (r_b_vld && r_b.flush) begin
            r_fl_top <= n_fl_top;
            r_fl_mid <= n_fl_mid;
        end
    end

    // ---------------------------------------------------------------
    // Sorting networks: window median and right-edge median
    mf_median u_med_a (
        .i_clk    (i_clk),
        .i_cells  (r_c_cells1),
        .o_median (med_a)
    );

    mf_median u_med_b (
        .i_clk    (i_clk),
        .i_cells  (r_c_cells2),
        .o_median (med_b)
    );

    always_comb begin
        push                   = '0;
        push.en1               = r_p_vld[LAT-1] && r_p_flg[LAT-1].emit1;
        push.en2               = r_p_vld[LAT-1] && r_p_flg[LAT-1].emit2;
        push.res1.median       = med_a;
        push.res1.end_of_row   = r_p_flg[LAT-1].last;
        push.res1.end_of_image = r_p_flg[LAT-1].last;
        push.res2.median       = med_b;
        push.res2.end_of_row   = 1'b1;
        push.res2.end_of_image = 1'b0;
    end

    // ---------------------------------------------------------------
    // Result queue and input back-pressure (two slots held per item in flight)
    mf_outq #(
        .DEPTH (mf_pkg::OUTQ_DEPTH)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (q_count),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

    assign inflight   = INFL_W'($countones({r_b_vld, r_c_vld, r_p_vld}));
    assign load       = LOAD_W'(q_count) + LOAD_W'({inflight, 1'b0}) + LOAD_W'(2);
    assign o_in_stall = load > LOAD_W'(mf_pkg::OUTQ_DEPTH);

endmodule

// ===== rtl/mf_check.sv =====
// Port-level checker for the 3x3 median filter, bound to the top level.
module mf_check (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_stall,
    input  logic         i_out_valid,
    input  logic         i_out_stall,
    input  mf_pkg::t_out i_out_data
);

    // A stalled result stays offered unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_stall) |=> (i_out_valid && $stable(i_out_data)))
        else $error("result changed or dropped while stalled");

    // Reset empties the result queue
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // Reset leaves room for new items
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_stall)
        else $error("input stalled right after reset");

    // The last median of an image also closes its row
    a_eoi_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.end_of_image) |-> i_out_data.end_of_row)
        else $error("end of image without end of row");

endmodule

bind median_filter_3x3 mf_check u_mf_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
